// ===== design/assert_macros.svh =====
// assertion macros shared by the filter modules
// no dependencies; included by the modules that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define CRF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CRF_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define CRF_ASSERT(lbl, clk, rst_n, prop, msg)
`define CRF_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== design/crf_pkg.sv =====
// shared types, constants and arithmetic helpers of the recursive filter
// no dependencies; used by every module of the block except crf_queue
package crf_pkg;

  localparam int MAX_LINE_DEF     = 2048;
  localparam int FILTER_ORDER_DEF = 3;
  localparam int TAPS             = 3;
  localparam int SAMPLE_W         = 32;
  localparam int WGT_W            = 18;
  localparam int FRAC_W           = 16;
  localparam int PROD_W           = 34;
  localparam int ACC_W            = 36;
  localparam int WIDTH_W          = 12;
  localparam int HEIGHT_W         = 16;
  localparam int ADDR_W           = 5;
  localparam int DATA_W           = 32;
  localparam int QDEPTH           = 2;

  localparam logic [2:0] REG_WX1    = 3'd0;
  localparam logic [2:0] REG_WX2    = 3'd1;
  localparam logic [2:0] REG_WX3    = 3'd2;
  localparam logic [2:0] REG_WY1    = 3'd3;
  localparam logic [2:0] REG_WY2    = 3'd4;
  localparam logic [2:0] REG_WY3    = 3'd5;
  localparam logic [2:0] REG_WIDTH  = 3'd6;
  localparam logic [2:0] REG_HEIGHT = 3'd7;

  localparam logic [WGT_W-1:0]    W1_RST     = 18'd8192;
  localparam logic [WGT_W-1:0]    W2_RST     = 18'd4096;
  localparam logic [WGT_W-1:0]    W3_RST     = 18'd2048;
  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd2048;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd1024;

  typedef struct packed {
    logic [TAPS-1:0][WGT_W-1:0] wx;
    logic [TAPS-1:0][WGT_W-1:0] wy;
    logic [WIDTH_W-1:0]         width;
    logic [HEIGHT_W-1:0]        height;
  } crf_cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] pixel;
    logic [TAPS-1:0]     xmask;
    logic [TAPS-1:0]     ymask;
    logic                last;
  } crf_item_t;

  // q1.16 weight times q15.16 sample, rounded half up to q17.16
  function automatic logic signed [PROD_W-1:0] mul_round(
    input logic signed [WGT_W-1:0]    w,
    input logic signed [SAMPLE_W-1:0] s
  );
    logic signed [WGT_W+SAMPLE_W:0] p;
    p = (WGT_W+SAMPLE_W+1)'(w) * (WGT_W+SAMPLE_W+1)'(s);
    p = p + (WGT_W+SAMPLE_W+1)'(1 << (FRAC_W-1));
    return p[WGT_W+SAMPLE_W-1:FRAC_W];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sat32(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-SAMPLE_W:0] top;
    top = a[ACC_W-1:SAMPLE_W-1];
    if ((&top) || !(|top)) begin
      return a[SAMPLE_W-1:0];
    end else if (a[ACC_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== design/crf_regs.sv =====
// configuration register file behind the apb-style port
// depends on crf_pkg for the register codes, reset values and config struct
module crf_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [crf_pkg::ADDR_W-1:0]     paddr,
  input  logic [crf_pkg::DATA_W-1:0]     pwdata,
  output logic [crf_pkg::DATA_W-1:0]     prdata,
  output logic                           pready,
  output crf_pkg::crf_cfg_t              cfg
);

  logic [crf_pkg::TAPS-1:0][crf_pkg::WGT_W-1:0] wx_r;
  logic [crf_pkg::TAPS-1:0][crf_pkg::WGT_W-1:0] wy_r;
  logic [crf_pkg::WIDTH_W-1:0]                  width_r;
  logic [crf_pkg::HEIGHT_W-1:0]                 height_r;
  logic [2:0]                                   idx;
  logic                                         wr;

  assign idx    = paddr[crf_pkg::ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wx_r     <= {crf_pkg::W3_RST, crf_pkg::W2_RST, crf_pkg::W1_RST};
      wy_r     <= {crf_pkg::W3_RST, crf_pkg::W2_RST, crf_pkg::W1_RST};
      width_r  <= crf_pkg::WIDTH_RST;
      height_r <= crf_pkg::HEIGHT_RST;
    end else if (wr) begin
      unique case (idx)
        crf_pkg::REG_WX1:    wx_r[0]  <= pwdata[crf_pkg::WGT_W-1:0];
        crf_pkg::REG_WX2:    wx_r[1]  <= pwdata[crf_pkg::WGT_W-1:0];
        crf_pkg::REG_WX3:    wx_r[2]  <= pwdata[crf_pkg::WGT_W-1:0];
        crf_pkg::REG_WY1:    wy_r[0]  <= pwdata[crf_pkg::WGT_W-1:0];
        crf_pkg::REG_WY2:    wy_r[1]  <= pwdata[crf_pkg::WGT_W-1:0];
        crf_pkg::REG_WY3:    wy_r[2]  <= pwdata[crf_pkg::WGT_W-1:0];
        crf_pkg::REG_WIDTH:  width_r  <= pwdata[crf_pkg::WIDTH_W-1:0];
        crf_pkg::REG_HEIGHT: height_r <= pwdata[crf_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      crf_pkg::REG_WX1:    prdata = crf_pkg::DATA_W'(wx_r[0]);
      crf_pkg::REG_WX2:    prdata = crf_pkg::DATA_W'(wx_r[1]);
      crf_pkg::REG_WX3:    prdata = crf_pkg::DATA_W'(wx_r[2]);
      crf_pkg::REG_WY1:    prdata = crf_pkg::DATA_W'(wy_r[0]);
      crf_pkg::REG_WY2:    prdata = crf_pkg::DATA_W'(wy_r[1]);
      crf_pkg::REG_WY3:    prdata = crf_pkg::DATA_W'(wy_r[2]);
      crf_pkg::REG_WIDTH:  prdata = crf_pkg::DATA_W'(width_r);
      crf_pkg::REG_HEIGHT: prdata = crf_pkg::DATA_W'(height_r);
      default:             prdata = '0;
    endcase
  end

  assign cfg.wx     = wx_r;
  assign cfg.wy     = wy_r;
  assign cfg.width  = width_r;
  assign cfg.height = height_r;

endmodule

// ===== design/crf_front.sv =====
// front end: takes input items, tracks raster position, marks active taps
// depends on crf_pkg for the config and item structs
`include "assert_macros.svh"

module crf_front #(
  parameter int MAX_LINE     = crf_pkg::MAX_LINE_DEF,
  parameter int FILTER_ORDER = crf_pkg::FILTER_ORDER_DEF,
  parameter int COL_W        = $clog2(MAX_LINE)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crf_pkg::crf_cfg_t             cfg,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [crf_pkg::SAMPLE_W-1:0]  in_tdata,
  input  logic                          q_full,
  output logic                          q_push,
  output crf_pkg::crf_item_t            q_item,
  output logic [COL_W-1:0]              q_col
);

  localparam int LEN_W = ($clog2(MAX_LINE + 1) > crf_pkg::WIDTH_W) ?
                         $clog2(MAX_LINE + 1) : crf_pkg::WIDTH_W;

  logic [COL_W-1:0]             col_r;
  logic [crf_pkg::HEIGHT_W-1:0] row_r;
  logic [LEN_W-1:0]             w_cfg;
  logic [LEN_W-1:0]             w_eff;
  logic [LEN_W-1:0]             col_inc;
  logic [crf_pkg::HEIGHT_W-1:0] h_eff;
  logic [crf_pkg::HEIGHT_W:0]   row_inc;
  logic                         row_end;
  logic                         frame_end;

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    w_cfg = LEN_W'(cfg.width);
    if (w_cfg == '0) begin
      w_eff = LEN_W'(1);
    end else if (w_cfg > LEN_W'(MAX_LINE)) begin
      w_eff = LEN_W'(MAX_LINE);
    end else begin
      w_eff = w_cfg;
    end
    h_eff     = (cfg.height == '0) ? crf_pkg::HEIGHT_W'(1) : cfg.height;
    col_inc   = LEN_W'(col_r) + LEN_W'(1);
    row_inc   = {1'b0, row_r} + (crf_pkg::HEIGHT_W+1)'(1);
    row_end   = col_inc >= w_eff;
    frame_end = row_end && (row_inc >= {1'b0, h_eff});
  end

  always_comb begin
    q_item.pixel = in_tdata;
    q_item.last  = frame_end;
    for (int k = 0; k < crf_pkg::TAPS; k++) begin
      q_item.xmask[k] = (k < FILTER_ORDER) && (col_r > COL_W'(k));
      q_item.ymask[k] = (k < FILTER_ORDER) && (row_r > crf_pkg::HEIGHT_W'(k));
    end
  end

  assign q_col = col_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (q_push) begin
      if (row_end) begin
        col_r <= '0;
        row_r <= frame_end ? '0 : row_inc[crf_pkg::HEIGHT_W-1:0];
      end else begin
        col_r <= col_inc[COL_W-1:0];
      end
    end
  end

  `CRF_ASSERT(a_col_range, clk, rst_n, int'(col_r) < MAX_LINE, "column out of range")
  `CRF_ASSERT(a_frame_wrap, clk, rst_n, (q_push && q_item.last) |=> (col_r == '0 && row_r == '0), "no wrap at frame end")

endmodule

// ===== design/crf_queue.sv =====
// small register fifo between front and back end
// no package dependencies beyond the shared assertion macros
`include "assert_macros.svh"

module crf_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output logic              valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] store_r [DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full  = count_r == CNT_W'(DEPTH);
  assign valid = count_r != '0;
  assign rdata = store_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
      end
      if (pop) begin
        rptr_r <= (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wptr_r] <= wdata;
    end
  end

  `CRF_NEVER(a_no_overflow, clk, rst_n, push && full, "push into full queue")
  `CRF_NEVER(a_no_underflow, clk, rst_n, pop && !valid, "pop from empty queue")

endmodule

// ===== design/crf_back.sv =====
// back end: row recursion, line store with column recursion, output register
// depends on crf_pkg for structs, mul_round and sat32
`include "assert_macros.svh"

module crf_back #(
  parameter int MAX_LINE     = crf_pkg::MAX_LINE_DEF,
  parameter int FILTER_ORDER = crf_pkg::FILTER_ORDER_DEF,
  parameter int COL_W        = $clog2(MAX_LINE)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  crf_pkg::crf_cfg_t             cfg,
  input  logic                          q_valid,
  input  crf_pkg::crf_item_t            q_item,
  input  logic [COL_W-1:0]              q_col,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [crf_pkg::SAMPLE_W-1:0]  out_tdata,
  output logic                          out_tlast
);

  localparam int WORD_W = FILTER_ORDER * crf_pkg::SAMPLE_W;

  logic [WORD_W-1:0] line_mem [MAX_LINE];

  logic [FILTER_ORDER-1:0][crf_pkg::SAMPLE_W-1:0] hist_r;
  logic [FILTER_ORDER-1:0][crf_pkg::SAMPLE_W-1:0] mem_q_r;
  logic [FILTER_ORDER-1:0][crf_pkg::SAMPLE_W-1:0] fwd_word_r;
  logic [FILTER_ORDER-1:0][crf_pkg::SAMPLE_W-1:0] col_word;
  logic [FILTER_ORDER-1:0][crf_pkg::SAMPLE_W-1:0] word_nxt;

  logic                          s1_valid_r;
  logic [crf_pkg::SAMPLE_W-1:0]  s1_h_r;
  logic [COL_W-1:0]              s1_col_r;
  logic [crf_pkg::TAPS-1:0]      s1_ymask_r;
  logic                          s1_last_r;
  logic                          fwd_valid_r;
  logic [COL_W-1:0]              fwd_col_r;
  logic                          out_valid_r;
  logic [crf_pkg::SAMPLE_W-1:0]  out_data_r;
  logic                          out_last_r;

  logic                          adv;
  logic signed [crf_pkg::ACC_W-1:0] row_acc;
  logic signed [crf_pkg::ACC_W-1:0] col_acc;
  logic [crf_pkg::SAMPLE_W-1:0]  h_nxt;
  logic [crf_pkg::SAMPLE_W-1:0]  res_nxt;

  assign adv   = !out_valid_r || out_tready;
  assign q_pop = adv && q_valid;

  // row recursion on the queue head
  always_comb begin
    row_acc = crf_pkg::ACC_W'($signed(q_item.pixel));
    for (int k = 0; k < FILTER_ORDER; k++) begin
      if (q_item.xmask[k]) begin
        row_acc = row_acc + crf_pkg::ACC_W'(
                  crf_pkg::mul_round($signed(cfg.wx[k]), $signed(hist_r[k])));
      end
    end
    h_nxt = crf_pkg::sat32(row_acc);
  end

  // column recursion, bypassing the write that raced the line read
  always_comb begin
    col_word = (fwd_valid_r && (fwd_col_r == s1_col_r)) ? fwd_word_r : mem_q_r;
    col_acc  = crf_pkg::ACC_W'($signed(s1_h_r));
    for (int k = 0; k < FILTER_ORDER; k++) begin
      if (s1_ymask_r[k]) begin
        col_acc = col_acc + crf_pkg::ACC_W'(
                  crf_pkg::mul_round($signed(cfg.wy[k]), $signed(col_word[k])));
      end
    end
    res_nxt     = crf_pkg::sat32(col_acc);
    word_nxt[0] = res_nxt;
    for (int k = 1; k < FILTER_ORDER; k++) begin
      word_nxt[k] = col_word[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      fwd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= q_pop;
      fwd_valid_r <= s1_valid_r;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_h_r     <= h_nxt;
      s1_col_r   <= q_col;
      s1_ymask_r <= q_item.ymask;
      s1_last_r  <= q_item.last;
      hist_r[0]  <= h_nxt;
      for (int k = 1; k < FILTER_ORDER; k++) begin
        hist_r[k] <= hist_r[k-1];
      end
    end
    if (adv) begin
      fwd_col_r  <= s1_col_r;
      fwd_word_r <= word_nxt;
    end
    if (adv && s1_valid_r) begin
      out_data_r <= res_nxt;
      out_last_r <= s1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem_q_r <= line_mem[q_col];
    end
    if (adv && s1_valid_r) begin
      line_mem[s1_col_r] <= word_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `CRF_ASSERT(a_s1_hold, clk, rst_n, (s1_valid_r && !adv) |=> s1_valid_r, "stage item lost")
  `CRF_ASSERT(a_out_from_s1, clk, rst_n, $rose(out_valid_r) |-> $past(s1_valid_r), "result without item")

endmodule

// ===== design/causal_2d_recursive_filter.sv =====
// a taken item is registered in stage s1 and then in the output register
// throughput: one item per cycle while out_tready does not hold the output,
// set by the row and column feedback loops and the one-read one-write line store
// synchronous active-low reset clears counters, queue and valid flags;
// configuration returns to its reset values and the line store is not cleared
module causal_2d_recursive_filter #(
  parameter int MAX_LINE     = crf_pkg::MAX_LINE_DEF,
  parameter int FILTER_ORDER = crf_pkg::FILTER_ORDER_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [crf_pkg::SAMPLE_W-1:0]  in_tdata,   // [31:0] pixel_in
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [crf_pkg::SAMPLE_W-1:0]  out_tdata,  // [31:0] pixel_out
  output logic                          out_tlast,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [crf_pkg::ADDR_W-1:0]    paddr,
  input  logic [crf_pkg::DATA_W-1:0]    pwdata,
  output logic [crf_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int COL_W = $clog2(MAX_LINE);
  localparam int QW    = $bits(crf_pkg::crf_item_t) + COL_W;

  crf_pkg::crf_cfg_t  cfg;
  crf_pkg::crf_item_t f_item;
  crf_pkg::crf_item_t b_item;
  logic [COL_W-1:0]   f_col;
  logic [COL_W-1:0]   b_col;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_valid;
  logic [QW-1:0]      q_rdata;

  crf_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crf_front #(
    .MAX_LINE     (MAX_LINE),
    .FILTER_ORDER (FILTER_ORDER),
    .COL_W        (COL_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (f_item),
    .q_col     (f_col)
  );

  crf_queue #(
    .DATA_W (QW),
    .DEPTH  (crf_pkg::QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata ({f_col, f_item}),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .valid (q_valid)
  );

  assign b_item = q_rdata[$bits(crf_pkg::crf_item_t)-1:0];
  assign b_col  = q_rdata[QW-1:$bits(crf_pkg::crf_item_t)];

  crf_back #(
    .MAX_LINE     (MAX_LINE),
    .FILTER_ORDER (FILTER_ORDER),
    .COL_W        (COL_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_item     (b_item),
    .q_col      (b_col),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
